// ===== hdl/compass_heading_degrees_top_assert.svh =====
// Assertion macros shared by the compass heading RTL.
`ifndef COMPASS_HEADING_DEGREES_TOP_ASSERT_SVH
`define COMPASS_HEADING_DEGREES_TOP_ASSERT_SVH

// Checks a same-cycle implication, quiet while reset is high.
`define CHD_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks what must hold in the cycle after reset has been applied.
`define CHD_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/chd_pkg.sv =====
// Types, constants and the CORDIC angle table for the compass heading block.
package chd_pkg;

   localparam int CORDIC_STAGES_DEF   = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 16;

   // Samples are magnitudes of up to 17 bits, pre-scaled by 2^16, and grow
   // by the CORDIC gain; 36 signed bits hold every intermediate value.
   localparam int PRESCALE   = 16;
   localparam int XY_W       = 36;
   localparam int TABLE_FRAC = 24;
   localparam int TABLE_LEN  = 24;
   localparam int SCALE_W    = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_SCALE  = 2'd0,
      CSR_Y_SCALE  = 2'd1,
      CSR_X_OFFSET = 2'd2,
      CSR_Y_OFFSET = 2'd3
   } csr_index_type;

   localparam logic signed [8:0] DEG_0     = 9'sd0;
   localparam logic signed [8:0] DEG_45    = 9'sd45;
   localparam logic signed [8:0] DEG_90    = 9'sd90;
   localparam logic signed [8:0] DEG_135   = 9'sd135;
   localparam logic signed [8:0] DEG_180   = 9'sd180;

   // atan(2^-i) in degrees with 24 fractional bits.
   localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
      32'd234684,    32'd117342,    32'd58671,     32'd29335,
      32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115
   };

   typedef struct packed {
      logic signed [15:0] x_sample;
      logic signed [15:0] y_sample;
   } req_type;

   typedef struct packed {
      logic signed [8:0]  heading_deg;
      logic signed [15:0] cal_x;
      logic signed [15:0] cal_y;
   } rsp_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
   } vec_type;

   // Travels alongside the rotation: calibrated values, quadrant and the
   // answer for axes and diagonals, which bypass the CORDIC result.
   typedef struct packed {
      logic signed [15:0] cal_x;
      logic signed [15:0] cal_y;
      logic               x_neg;
      logic               y_neg;
      logic               fixed;
      logic signed [8:0]  fixed_deg;
   } side_type;

   // Angle of one micro-rotation, rounded to the requested fraction.
   function automatic logic [31:0] step_angle(input int stage, input int frac);
      logic [31:0] t;
      if (stage >= TABLE_LEN) begin
         return 32'd0;
      end
      t = ATAN_TABLE[stage];
      if (frac >= TABLE_FRAC) begin
         return t;
      end
      return (t + (32'd1 << (TABLE_FRAC - 1 - frac))) >> (TABLE_FRAC - frac);
   endfunction

endpackage

// ===== hdl/compass_heading_degrees_top.sv =====
// Top level of the compass heading block: registers, pipeline and checks.
`include "compass_heading_degrees_top_assert.svh"

// Compass heading block. Each word on the req_ channel carries one signed
// X/Y magnetometer sample pair; each axis is calibrated as scale * sample +
// offset and clamped to the signed 16-bit range, and the rsp_ word returns
// the heading atan2(cal_y, cal_x) in whole degrees, truncated toward zero
// (-180..180), together with both calibrated values. The origin, the axes
// and the exact diagonals give exact angles. The block takes one word per
// clock cycle while rsp_stall stays low, and holds up to CORDIC_STAGES + 4
// words in flight: three calibration stages (multiply, offset and clamp,
// CORDIC set-up), one stage per CORDIC micro-rotation and a final output
// register. Every stage moves on as soon as the one after it is empty or
// moving, so a stall on the rsp_ side only reaches req_stall once all stages
// are full. The four calibration registers are written through csr_wr_en,
// csr_index and csr_wdata (index 0 X scale, 1 Y scale, 2 X offset, 3 Y
// offset) and are to be changed only while no word is in flight.
// ANGLE_FRAC_BITS sets the fraction of a degree that the angle accumulator
// carries.
module compass_heading_degrees_top #(
   parameter int CORDIC_STAGES   = chd_pkg::CORDIC_STAGES_DEF,
   parameter int ANGLE_FRAC_BITS = chd_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  chd_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output chd_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [chd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [chd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ZW = ANGLE_FRAC_BITS + 9;

   // Calibration registers; they reset to unit scale and zero offset.
   logic [chd_pkg::SCALE_W-1:0] x_scale_ff, y_scale_ff;
   logic signed [15:0]          x_offset_ff, y_offset_ff;

   // Links between pipeline sections: index k feeds CORDIC stage k.
   logic                 link_valid [CORDIC_STAGES+1];
   logic                 link_ready [CORDIC_STAGES+1];
   chd_pkg::vec_type     link_vec   [CORDIC_STAGES+1];
   logic signed [ZW-1:0] link_z     [CORDIC_STAGES+1];
   chd_pkg::side_type    link_side  [CORDIC_STAGES+1];
   logic                 calib_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff  <= chd_pkg::SCALE_W'(1);
         y_scale_ff  <= chd_pkg::SCALE_W'(1);
         x_offset_ff <= 16'sd0;
         y_offset_ff <= 16'sd0;
      end else if (csr_wr_en) begin
         case (chd_pkg::csr_index_type'(csr_index))
            chd_pkg::CSR_X_SCALE: begin
               x_scale_ff <= csr_wdata[chd_pkg::SCALE_W-1:0];
            end
            chd_pkg::CSR_Y_SCALE: begin
               y_scale_ff <= csr_wdata[chd_pkg::SCALE_W-1:0];
            end
            chd_pkg::CSR_X_OFFSET: begin
               x_offset_ff <= csr_wdata[15:0];
            end
            chd_pkg::CSR_Y_OFFSET: begin
               y_offset_ff <= csr_wdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   chd_calib u_calib (
      .clock     (clock),
      .reset     (reset),
      .x_scale   (x_scale_ff),
      .y_scale   (y_scale_ff),
      .x_offset  (x_offset_ff),
      .y_offset  (y_offset_ff),
      .in_valid  (req_valid),
      .in_ready  (calib_ready),
      .in_data   (req_data),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_vec   (link_vec[0]),
      .out_side  (link_side[0])
   );

   assign req_stall = !calib_ready;

   // The angle accumulator starts at zero for every word.
   assign link_z[0] = '0;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      chd_cordic_stage #(
         .STAGE           (k),
         .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_vec    (link_vec[k]),
         .in_z      (link_z[k]),
         .in_side   (link_side[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_vec   (link_vec[k+1]),
         .out_z     (link_z[k+1]),
         .out_side  (link_side[k+1])
      );
   end

   chd_resolve #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[CORDIC_STAGES]),
      .in_ready  (link_ready[CORDIC_STAGES]),
      .in_z      (link_z[CORDIC_STAGES]),
      .in_side   (link_side[CORDIC_STAGES]),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   // The heading always lies within a half turn either way.
   `CHD_ASSERT(a_heading_range, rsp_valid, (rsp_data.heading_deg >= -180) && (rsp_data.heading_deg <= 180), "heading outside -180..180")
   // A sample on the X axis points straight ahead or straight back.
   `CHD_ASSERT(a_x_axis, rsp_valid && (rsp_data.cal_y == 16'sd0), (rsp_data.heading_deg == 0) || (rsp_data.heading_deg == 180), "X axis sample gave a skew heading")
   // A sample on the Y axis gives a right angle with the sign of Y.
   `CHD_ASSERT(a_y_axis, rsp_valid && (rsp_data.cal_x == 16'sd0) && (rsp_data.cal_y != 16'sd0), (rsp_data.heading_deg == (rsp_data.cal_y[15] ? -90 : 90)), "Y axis sample gave a wrong right angle")
   // A non-negative Y never yields a negative heading.
   `CHD_ASSERT(a_upper_half, rsp_valid && !rsp_data.cal_y[15], !rsp_data.heading_deg[8], "upper half plane gave a negative heading")
   // Reset empties the whole pipeline.
   `CHD_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid && !req_stall, "pipeline not empty after reset")

endmodule

// ===== hdl/chd_calib.sv =====
// Calibration pipeline: scale, offset with saturation, then CORDIC set-up.
module chd_calib (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [chd_pkg::SCALE_W-1:0] x_scale,
   input  logic [chd_pkg::SCALE_W-1:0] y_scale,
   input  logic signed [15:0]          x_offset,
   input  logic signed [15:0]          y_offset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  chd_pkg::req_type            in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output chd_pkg::vec_type            out_vec,
   output chd_pkg::side_type           out_side
);

   localparam int MAG_W = 17;

   logic mul_valid_ff, sum_valid_ff, prep_valid_ff;
   logic mul_ready, sum_ready, prep_ready;

   logic signed [23:0] scale_x_ext, scale_y_ext, samp_x_ext, samp_y_ext;
   logic signed [23:0] prod_x_in, prod_y_in, prod_x_ff, prod_y_ff;
   logic signed [24:0] sum_x, sum_y;
   logic signed [15:0] cal_x_in, cal_y_in, cal_x_ff, cal_y_ff;
   logic signed [MAG_W-1:0] ext_x, ext_y;
   logic [MAG_W-1:0]        mag_x, mag_y;
   logic signed [8:0]       diag_deg;
   chd_pkg::vec_type  vec_in, vec_ff;
   chd_pkg::side_type side_in, side_ff;

   assign prep_ready = !prep_valid_ff || out_ready;
   assign sum_ready  = !sum_valid_ff || prep_ready;
   assign mul_ready  = !mul_valid_ff || sum_ready;
   assign in_ready   = mul_ready;

   // Stage one: the two small multiplications.
   always_comb begin
      scale_x_ext = {17'b0, x_scale};
      scale_y_ext = {17'b0, y_scale};
      samp_x_ext  = {{8{in_data.x_sample[15]}}, in_data.x_sample};
      samp_y_ext  = {{8{in_data.y_sample[15]}}, in_data.y_sample};
      prod_x_in   = scale_x_ext * samp_x_ext;
      prod_y_in   = scale_y_ext * samp_y_ext;
   end

   // Stage two: add the offset and clamp to 16 bits.
   always_comb begin
      sum_x = {prod_x_ff[23], prod_x_ff} + {{9{x_offset[15]}}, x_offset};
      sum_y = {prod_y_ff[23], prod_y_ff} + {{9{y_offset[15]}}, y_offset};
      if (sum_x[24:15] != {10{sum_x[24]}}) begin
         cal_x_in = sum_x[24] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         cal_x_in = sum_x[15:0];
      end
      if (sum_y[24:15] != {10{sum_y[24]}}) begin
         cal_y_in = sum_y[24] ? 16'sh8000 : 16'sh7FFF;
      end else begin
         cal_y_in = sum_y[15:0];
      end
   end

   // Stage three: magnitudes, quadrant and the cases with an exact answer.
   always_comb begin
      ext_x = {cal_x_ff[15], cal_x_ff};
      ext_y = {cal_y_ff[15], cal_y_ff};
      mag_x = cal_x_ff[15] ? MAG_W'(-ext_x) : MAG_W'(ext_x);
      mag_y = cal_y_ff[15] ? MAG_W'(-ext_y) : MAG_W'(ext_y);

      vec_in.x = {{(chd_pkg::XY_W - MAG_W - chd_pkg::PRESCALE){1'b0}}, mag_x,
                  {chd_pkg::PRESCALE{1'b0}}};
      vec_in.y = {{(chd_pkg::XY_W - MAG_W - chd_pkg::PRESCALE){1'b0}}, mag_y,
                  {chd_pkg::PRESCALE{1'b0}}};

      side_in.cal_x = cal_x_ff;
      side_in.cal_y = cal_y_ff;
      side_in.x_neg = cal_x_ff[15];
      side_in.y_neg = cal_y_ff[15];
      side_in.fixed = (cal_y_ff == 16'sd0) || (cal_x_ff == 16'sd0) || (mag_x == mag_y);

      diag_deg = cal_x_ff[15] ? chd_pkg::DEG_135 : chd_pkg::DEG_45;
      if (cal_y_ff == 16'sd0) begin
         side_in.fixed_deg = cal_x_ff[15] ? chd_pkg::DEG_180 : chd_pkg::DEG_0;
      end else if (cal_x_ff == 16'sd0) begin
         side_in.fixed_deg = cal_y_ff[15] ? -chd_pkg::DEG_90 : chd_pkg::DEG_90;
      end else begin
         side_in.fixed_deg = cal_y_ff[15] ? -diag_deg : diag_deg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff  <= 1'b0;
         sum_valid_ff  <= 1'b0;
         prep_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (sum_ready) begin
            sum_valid_ff <= mul_valid_ff;
         end
         if (prep_ready) begin
            prep_valid_ff <= sum_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
      if (sum_ready && mul_valid_ff) begin
         cal_x_ff <= cal_x_in;
         cal_y_ff <= cal_y_in;
      end
      if (prep_ready && sum_valid_ff) begin
         vec_ff  <= vec_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = prep_valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

// ===== hdl/chd_cordic_stage.sv =====
// One registered micro-rotation of the vectoring CORDIC.
module chd_cordic_stage #(
   parameter int STAGE           = 0,
   parameter int ANGLE_FRAC_BITS = chd_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  chd_pkg::vec_type                    in_vec,
   input  logic signed [ANGLE_FRAC_BITS+8:0]   in_z,
   input  chd_pkg::side_type                   in_side,
   output logic                                out_valid,
   input  logic                                out_ready,
   output chd_pkg::vec_type                    out_vec,
   output logic signed [ANGLE_FRAC_BITS+8:0]   out_z,
   output chd_pkg::side_type                   out_side
);

   localparam int ZW = ANGLE_FRAC_BITS + 9;
   localparam logic signed [ZW-1:0] STEP =
      ZW'(chd_pkg::step_angle(STAGE, ANGLE_FRAC_BITS));

   logic                  valid_ff;
   logic                  ready;
   logic signed [chd_pkg::XY_W-1:0] sx, sy;
   chd_pkg::vec_type      vec_in, vec_ff;
   logic signed [ZW-1:0]  z_in, z_ff;
   chd_pkg::side_type     side_ff;

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   // Rotate towards the X axis; the sign of y picks the direction.
   always_comb begin
      sx = in_vec.x >>> STAGE;
      sy = in_vec.y >>> STAGE;
      if (in_vec.y > 0) begin
         vec_in.x = in_vec.x + sy;
         vec_in.y = in_vec.y - sx;
         z_in     = in_z + STEP;
      end else begin
         vec_in.x = in_vec.x - sy;
         vec_in.y = in_vec.y + sx;
         z_in     = in_z - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         vec_ff  <= vec_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

// ===== hdl/chd_resolve.sv =====
// Output stage: clamps the angle, reflects it into its quadrant, truncates to whole degrees.
module chd_resolve #(
   parameter int ANGLE_FRAC_BITS = chd_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [ANGLE_FRAC_BITS+8:0] in_z,
   input  chd_pkg::side_type                 in_side,
   output logic                              out_valid,
   input  logic                              out_ready,
   output chd_pkg::rsp_type                  out_data
);

   localparam int ZW = ANGLE_FRAC_BITS + 9;
   localparam logic signed [ZW-1:0] QUARTER = ZW'(90) << ANGLE_FRAC_BITS;
   localparam logic signed [ZW-1:0] HALF    = ZW'(180) << ANGLE_FRAC_BITS;

   logic                 valid_ff;
   logic                 ready;
   logic signed [ZW-1:0] clamped, reflected;
   logic [7:0]           whole;
   chd_pkg::rsp_type     data_in, data_ff;

   assign ready    = !valid_ff || out_ready;
   assign in_ready = ready;

   always_comb begin
      if (in_z < 0) begin
         clamped = '0;
      end else if (in_z > QUARTER) begin
         clamped = QUARTER;
      end else begin
         clamped = in_z;
      end
      reflected = in_side.x_neg ? HALF - clamped : clamped;
      whole     = reflected[ANGLE_FRAC_BITS +: 8];

      data_in.cal_x = in_side.cal_x;
      data_in.cal_y = in_side.cal_y;
      if (in_side.fixed) begin
         data_in.heading_deg = in_side.fixed_deg;
      end else if (in_side.y_neg) begin
         data_in.heading_deg = -$signed({1'b0, whole});
      end else begin
         data_in.heading_deg = $signed({1'b0, whole});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
